// ===== hdl/accel_magnitude_step_counter_top_defines.svh =====
// Assertion macros used by the step counter sequencer
`ifndef ACCEL_MAGNITUDE_STEP_COUNTER_TOP_DEFINES_SVH
`define ACCEL_MAGNITUDE_STEP_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AMSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("step counter assertion failed");

// next-cycle implication, checked out of reset
`define AMSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("step counter assertion failed");

`endif

// ===== hdl/amsc_pkg.sv =====
// Types and constants of the accelerometer step counter
package amsc_pkg;

    localparam int CAL_SAMPLES = 128;              // power of two
    localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES);
    localparam int CNT_W       = $clog2(CAL_SAMPLES);
    localparam int ACC_W       = 16;
    localparam int SUM_W       = 24;
    localparam int DIFF_W      = ACC_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int MAG_W       = 17;
    localparam int REM_W       = MAG_W + 2;
    localparam int STEP_W      = 16;
    localparam int ROOT_STEPS  = SQ_W / 2;
    localparam int SEQ_W       = $clog2(ROOT_STEPS);
    localparam logic [MAG_W-1:0] THRESHOLD_RESET = MAG_W'(2458);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_NONE
    } axis_t;

    typedef struct packed {
        logic                     mode;
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
    } in_word_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_count;
        logic [MAG_W-1:0]  smoothed_magnitude;
        logic              step_armed_flag;
        logic              calibration_done;
    } out_word_t;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        axis_t mul_sel;
        logic  acc_clr;
        logic  acc_en;
        logic  root_init;
        logic  root_step;
        logic  finish;
    } cmd_t;

    typedef struct packed {
        logic in_mode;
    } status_t;

endpackage

// ===== hdl/accel_magnitude_step_counter_top.sv =====
// Top level of the accelerometer step counter
//
// Input channel in_valid/in_stall/in_word carries one raw three-axis sample
// per word, tagged calibration (mode 0) or measurement (mode 1). Output
// channel out_valid/out_stall/out_word returns exactly one result word per
// input word, in order. cfg_we/cfg_wdata write the step threshold; write it
// only while no word is in flight.
//
// A calibration word goes from accept straight to the result step; a
// measurement word is first squared and rooted: one shared 17x17 multiplier
// squares the three axes, then a restoring digit-recurrence square root takes
// one result bit per cycle until all 17 root bits are formed. One word is in
// work at a time; the next is taken once the last has left the result step.
//
// Reset clears the sums, offsets, detector, step count and threshold (to
// 2458) at once; the block takes a word in the first cycle after reset.
// The result register holds a finished word while out_stall is high; the
// next input word is still taken and worked, and its result waits in the
// finish step until the register frees.
module accel_magnitude_step_counter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  amsc_pkg::in_word_t          in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output amsc_pkg::out_word_t         out_word,
    input  logic                        cfg_we,
    input  logic [amsc_pkg::MAG_W-1:0]  cfg_wdata
);
    import amsc_pkg::*;

    cmd_t    cmd;
    status_t status;

    amsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    amsc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_word)
    );

endmodule

// ===== hdl/amsc_ctrl.sv =====
// Sequencer of the step counter: input accept, square, root and result steps
`include "accel_magnitude_step_counter_top_defines.svh"
module amsc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  amsc_pkg::status_t status,
    output amsc_pkg::cmd_t    cmd
);
    import amsc_pkg::*;

    state_t           state_reg, state_next;
    logic [SEQ_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;
    logic             out_free;

    assign in_fire  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = status.in_mode ? ST_MUL : ST_FINISH;
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + SEQ_W'(1);
                if (cnt_reg == SEQ_W'(AXIS_NONE))
                begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + SEQ_W'(1);
                if (cnt_reg == SEQ_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = AXIS_NONE;
        in_stall       = (state_reg != ST_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_fire;
            end
            ST_MUL:
            begin
                cmd.mul_sel = axis_t'(cnt_reg[1:0]);
                cmd.mul_en  = (cnt_reg != SEQ_W'(AXIS_NONE));
                cmd.acc_clr = (cnt_reg == SEQ_W'(AXIS_X));
                cmd.acc_en  = (cnt_reg != SEQ_W'(AXIS_X));
            end
            ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `AMSC_ASSERT_NEXT(a_meas_to_mul, in_fire && status.in_mode, state_reg == ST_MUL)
    `AMSC_ASSERT_NEXT(a_cal_to_finish, in_fire && !status.in_mode, state_reg == ST_FINISH)
    `AMSC_ASSERT_NEXT(a_finish_waits, (state_reg == ST_FINISH) && out_valid_reg && out_stall,
                      state_reg == ST_FINISH)
    `AMSC_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_reg)
    `AMSC_ASSERT_IMPL(a_root_bound, state_reg == ST_ROOT, cnt_reg < SEQ_W'(ROOT_STEPS))

endmodule

// ===== hdl/amsc_dpath.sv =====
// Datapath of the step counter: calibration sums, squares, root and detector
module amsc_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  amsc_pkg::in_word_t              in_word,
    input  logic                            cfg_we,
    input  logic [amsc_pkg::MAG_W-1:0]      cfg_wdata,
    input  amsc_pkg::cmd_t                  cmd,
    output amsc_pkg::status_t               status,
    output amsc_pkg::out_word_t             out_word
);
    import amsc_pkg::*;

    in_word_t                 in_reg;
    logic [MAG_W-1:0]         thr_reg;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]  sum_x_next, sum_y_next, sum_z_next;
    logic [CNT_W-1:0]         cal_cnt_reg;
    logic signed [ACC_W-1:0]  off_x_reg, off_y_reg, off_z_reg;
    logic [MAG_W-1:0]         prev_reg;
    logic                     above_reg, above_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic                     done_reg;
    logic signed [DIFF_W-1:0] diff;
    logic [SQ_W-1:0]          prod_reg;
    logic [SQ_W-1:0]          acc_reg;
    logic [SQ_W-1:0]          rad_reg;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [MAG_W-1:0]         root_reg, root_next;
    logic [REM_W+1:0]         rem_shift;
    logic [REM_W+1:0]         trial;
    logic [MAG_W:0]           pair;
    logic [MAG_W:0]           twice_t;
    logic                     rise, fall;
    logic                     cal_end;
    out_word_t                out_reg;

    assign status.in_mode = in_word.mode;

    always_comb
    begin
        case (cmd.mul_sel)
            AXIS_X:  diff = DIFF_W'(in_reg.accel_x) - DIFF_W'(off_x_reg);
            AXIS_Y:  diff = DIFF_W'(in_reg.accel_y) - DIFF_W'(off_y_reg);
            AXIS_Z:  diff = DIFF_W'(in_reg.accel_z) - DIFF_W'(off_z_reg);
            default: diff = '0;
        endcase
    end

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_next  = REM_W'(rem_shift - trial);
            root_next = {root_reg[MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = REM_W'(rem_shift);
            root_next = {root_reg[MAG_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        pair       = {1'b0, root_reg} + {1'b0, prev_reg};
        twice_t    = {thr_reg, 1'b0};
        rise       = (pair > twice_t) && !above_reg;
        fall       = (pair < twice_t) && above_reg;
        steps_next = steps_reg;
        if (rise && (steps_reg != {STEP_W{1'b1}}))
        begin
            steps_next = steps_reg + STEP_W'(1);
        end
        above_next = rise ? 1'b1 : (fall ? 1'b0 : above_reg);
        sum_x_next = sum_x_reg + SUM_W'(in_reg.accel_x);
        sum_y_next = sum_y_reg + SUM_W'(in_reg.accel_y);
        sum_z_next = sum_z_reg + SUM_W'(in_reg.accel_z);
        cal_end    = (cal_cnt_reg == CNT_W'(CAL_SAMPLES - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_word;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= SQ_W'(diff * diff);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.root_init)
        begin
            rad_reg  <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.finish)
        begin
            if (in_reg.mode)
            begin
                out_reg.step_count         <= steps_next;
                out_reg.smoothed_magnitude <= pair[MAG_W:1];
                out_reg.step_armed_flag    <= above_next;
                out_reg.calibration_done   <= done_reg;
            end
            else
            begin
                out_reg.step_count         <= steps_reg;
                out_reg.smoothed_magnitude <= '0;
                out_reg.step_armed_flag    <= above_reg;
                out_reg.calibration_done   <= done_reg || cal_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESHOLD_RESET;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_z_reg   <= '0;
            cal_cnt_reg <= '0;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            off_z_reg   <= '0;
            prev_reg    <= '0;
            above_reg   <= 1'b0;
            steps_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.finish && in_reg.mode)
            begin
                prev_reg  <= root_reg;
                above_reg <= above_next;
                steps_reg <= steps_next;
            end
            else if (cmd.finish)
            begin
                if (cal_end)
                begin
                    off_x_reg   <= ACC_W'(sum_x_next >>> CAL_SHIFT);
                    off_y_reg   <= ACC_W'(sum_y_next >>> CAL_SHIFT);
                    off_z_reg   <= ACC_W'(sum_z_next >>> CAL_SHIFT);
                    sum_x_reg   <= '0;
                    sum_y_reg   <= '0;
                    sum_z_reg   <= '0;
                    cal_cnt_reg <= '0;
                    done_reg    <= 1'b1;
                end
                else
                begin
                    sum_x_reg   <= sum_x_next;
                    sum_y_reg   <= sum_y_next;
                    sum_z_reg   <= sum_z_next;
                    cal_cnt_reg <= cal_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign out_word = out_reg;

endmodule
